@@ hw/rtl/speed_pid_with_bang_bang_fallback_core_defines.svh @@
// Assertion macros shared by the checker of the speed PID core.
`ifndef SPEED_PID_WITH_BANG_BANG_FALLBACK_CORE_DEFINES_SVH
`define SPEED_PID_WITH_BANG_BANG_FALLBACK_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define SPBB_ASSERT_NOW(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define SPBB_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

@@ hw/rtl/spbb_pkg.sv @@
// Types and constants of the speed PID core with bang-bang fallback.
`default_nettype none
package spbb_pkg;

	// Configuration register indexes.
	typedef enum logic [2:0] {
		REG_PROPORTIONAL_GAIN    = 3'd0,
		REG_INTEGRAL_GAIN        = 3'd1,
		REG_DERIVATIVE_GAIN      = 3'd2,
		REG_FORWARD_FAULT_DRIVE  = 3'd3,
		REG_BACKWARD_FAULT_DRIVE = 3'd4
	} reg_idx_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 16;

	// Reset value of both fault drive magnitudes.
	localparam logic [13:0] FAULT_DRIVE_RESET = 14'd2000;

	// Limits of the control law.
	localparam logic signed [15:0] TARGET_LIMIT     = 16'sd1500;
	localparam logic signed [11:0] FAULT_DEADBAND   = 12'sd100;
	localparam logic signed [26:0] INTEGRATOR_LIMIT = 27'sd4000;
	localparam logic signed [27:0] DTERM_LIMIT      = 28'sd7000;
	localparam logic signed [27:0] DRIVE_LIMIT      = 28'sd15000;

	// Configuration registers as seen by the control law.
	typedef struct packed {
		logic [15:0] kp;
		logic [15:0] ki;
		logic [15:0] kd;
		logic [13:0] forward_fault_drive;
		logic [13:0] backward_fault_drive;
	} cfg_t;

	// Controller state carried from one item to the next.
	typedef struct packed {
		logic signed [13:0] integrator;
		logic signed [16:0] previous_error;
		logic               previous_error_valid;
	} state_t;

	// One input item.
	typedef struct packed {
		logic               mode;
		logic signed [15:0] target_speed;
		logic signed [14:0] measured_speed;
		logic               feedback_fault;
	} item_t;

	// One result item.
	typedef struct packed {
		logic signed [14:0] drive;
		logic               drive_saturated;
	} result_t;

endpackage
`default_nettype wire

@@ hw/rtl/spbb_ifs.sv @@
// Channel interfaces of the speed PID core: input items, result items, configuration writes.
`default_nettype none

// Input item channel.
interface spbb_in_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [15:0] target_speed;
	logic signed [14:0] measured_speed;
	logic               feedback_fault;

	modport source (output valid, mode, target_speed, measured_speed, feedback_fault,
		input ready);
	modport sink (input valid, mode, target_speed, measured_speed, feedback_fault,
		output ready);
	modport monitor (input valid, ready, mode, target_speed, measured_speed, feedback_fault);
endinterface

// Result item channel.
interface spbb_out_if;
	logic               valid;
	logic               ready;
	logic signed [14:0] drive;
	logic               drive_saturated;

	modport source (output valid, drive, drive_saturated, input ready);
	modport sink (input valid, drive, drive_saturated, output ready);
	modport monitor (input valid, ready, drive, drive_saturated);
endinterface

// Configuration write channel.
interface spbb_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
	modport monitor (input valid, ready, index, data);
endinterface

`default_nettype wire

@@ hw/rtl/spbb_law.sv @@
// Control law of the speed PID core: one item's terms, clamps and next state.
`default_nettype none
module spbb_law
	import spbb_pkg::*;
(
	input  wire item_t  item,
	input  wire cfg_t   cfg,
	input  wire state_t st,
	output result_t     res,
	output state_t      st_next
);

	logic signed [11:0] target_c;
	logic signed [16:0] err;
	logic signed [33:0] p_prod;
	logic signed [33:0] i_prod;
	logic signed [17:0] diff;
	logic signed [34:0] d_prod;
	logic signed [25:0] p_scaled;
	logic signed [25:0] i_scaled;
	logic signed [26:0] d_scaled;
	logic signed [26:0] i_sum;
	logic signed [13:0] integ_upd;
	logic signed [27:0] d_neg;
	logic signed [13:0] d_term;
	logic signed [27:0] sum_normal;
	logic signed [27:0] sum_fault;
	logic signed [27:0] sum;

	// Target clamp and error.
	always_comb begin
		if (item.target_speed > TARGET_LIMIT) begin
			target_c = 12'(TARGET_LIMIT);
		end else if (item.target_speed < -TARGET_LIMIT) begin
			target_c = 12'(-TARGET_LIMIT);
		end else begin
			target_c = item.target_speed[11:0];
		end
		err = 17'(target_c) - 17'(item.measured_speed);
	end

	// The three gain products, each scaled by 1/256 rounding toward minus infinity.
	always_comb begin
		p_prod   = err * $signed({1'b0, cfg.kp});
		i_prod   = err * $signed({1'b0, cfg.ki});
		diff     = 18'(err) - 18'(st.previous_error);
		d_prod   = diff * $signed({1'b0, cfg.kd});
		p_scaled = $signed(p_prod[33:8]);
		i_scaled = $signed(i_prod[33:8]);
		d_scaled = $signed(d_prod[34:8]);
	end

	// Integrator update with its clamp.
	always_comb begin
		i_sum = 27'(st.integrator) + 27'(i_scaled);
		if (i_sum > INTEGRATOR_LIMIT) begin
			integ_upd = 14'(INTEGRATOR_LIMIT);
		end else if (i_sum < -INTEGRATOR_LIMIT) begin
			integ_upd = 14'(-INTEGRATOR_LIMIT);
		end else begin
			integ_upd = i_sum[13:0];
		end
	end

	// Derivative term, skipped when the previous error is not valid.
	always_comb begin
		d_neg = -28'(d_scaled);
		if (!st.previous_error_valid) begin
			d_term = '0;
		end else if (d_neg > DTERM_LIMIT) begin
			d_term = 14'(DTERM_LIMIT);
		end else if (d_neg < -DTERM_LIMIT) begin
			d_term = 14'(-DTERM_LIMIT);
		end else begin
			d_term = d_neg[13:0];
		end
	end

	// Drive before the output clamp, for normal and faulty feedback.
	always_comb begin
		sum_normal = -28'(p_scaled) - 28'(integ_upd) + 28'(d_term);
		if (target_c > FAULT_DEADBAND) begin
			sum_fault = -28'({1'b0, cfg.forward_fault_drive});
		end else if (target_c < -FAULT_DEADBAND) begin
			sum_fault = 28'({1'b0, cfg.backward_fault_drive});
		end else begin
			sum_fault = '0;
		end
		sum = item.feedback_fault ? sum_fault : sum_normal;
	end

	// Output clamp and saturation flag.
	always_comb begin
		res.drive_saturated = (sum > DRIVE_LIMIT) || (sum < -DRIVE_LIMIT);
		if (sum > DRIVE_LIMIT) begin
			res.drive = 15'(DRIVE_LIMIT);
		end else if (sum < -DRIVE_LIMIT) begin
			res.drive = 15'(-DRIVE_LIMIT);
		end else begin
			res.drive = sum[14:0];
		end
	end

	// Next state for a clear item, a faulty-feedback step or a normal step.
	always_comb begin
		st_next = st;
		if (item.mode) begin
			st_next.integrator = '0;
		end else if (item.feedback_fault) begin
			st_next.previous_error       = '0;
			st_next.previous_error_valid = 1'b0;
		end else begin
			st_next.integrator           = integ_upd;
			st_next.previous_error       = err;
			st_next.previous_error_valid = 1'b1;
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/speed_pid_with_bang_bang_fallback_core.sv @@
// Top level of the one-axis speed PID core with bang-bang fallback.
`default_nettype none
// The core takes one input item per clock cycle while the result register is free or being
// emptied. For a control step the item passes through the input register and then the result
// register, with the whole control law (three gain multiplies, clamps and the sum) between
// the two. The integrator and previous-error state are updated as the item moves into the
// result register, so the next item sees them at once and the sustained rate is one item per
// cycle. A clear item (mode 1) zeroes the integrator and produces no result. Input is
// held off only while the result register is full and not being taken. Configuration
// writes are always accepted and take effect on the next cycle.
module speed_pid_with_bang_bang_fallback_core
	import spbb_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	spbb_in_if.sink     items,
	spbb_out_if.source  results,
	spbb_cfg_if.sink    cfg
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_next;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_comb;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;

	// The input register moves on when the result register is free or being emptied.
	assign advance     = valid_s1 && (!res_valid_q || results.ready);
	assign items.ready = !valid_s1 || advance;
	assign cfg.ready   = 1'b1;

	// Configuration registers; an unknown index is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp                   <= '0;
			cfg_q.ki                   <= '0;
			cfg_q.kd                   <= '0;
			cfg_q.forward_fault_drive  <= FAULT_DRIVE_RESET;
			cfg_q.backward_fault_drive <= FAULT_DRIVE_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_PROPORTIONAL_GAIN:    cfg_q.kp <= cfg.data;
				REG_INTEGRAL_GAIN:        cfg_q.ki <= cfg.data;
				REG_DERIVATIVE_GAIN:      cfg_q.kd <= cfg.data;
				REG_FORWARD_FAULT_DRIVE:  cfg_q.forward_fault_drive <= cfg.data[13:0];
				REG_BACKWARD_FAULT_DRIVE: cfg_q.backward_fault_drive <= cfg.data[13:0];
				default: begin
				end
			endcase
		end
	end

	// Input register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	// Input register: payload.
	always_ff @(posedge clk) begin
		if (items.valid && items.ready) begin
			item_s1.mode           <= items.mode;
			item_s1.target_speed   <= items.target_speed;
			item_s1.measured_speed <= items.measured_speed;
			item_s1.feedback_fault <= items.feedback_fault;
		end
	end

	spbb_law u_law (
		.item    (item_s1),
		.cfg     (cfg_q),
		.st      (state_q),
		.res     (res_comb),
		.st_next (state_next)
	);

	// Controller state, updated as each item leaves the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.integrator           <= '0;
			state_q.previous_error       <= '0;
			state_q.previous_error_valid <= 1'b1;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register: valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= !item_s1.mode;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result register: payload, loaded only by a control step.
	always_ff @(posedge clk) begin
		if (advance && !item_s1.mode) begin
			res_q <= res_comb;
		end
	end

	assign results.valid           = res_valid_q;
	assign results.drive           = res_q.drive;
	assign results.drive_saturated = res_q.drive_saturated;

endmodule
`default_nettype wire

@@ hw/rtl/spbb_checker.sv @@
// Port-level checker of the speed PID core and its bind to the top level.
`default_nettype none
`include "speed_pid_with_bang_bang_fallback_core_defines.svh"
module spbb_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               valid,
	input  wire               ready,
	input  wire signed [14:0] drive,
	input  wire               drive_saturated
);

	localparam logic signed [14:0] DRIVE_MAX = 15'sd15000;

	// The drive never leaves the output range.
	`SPBB_ASSERT_NOW(a_drive_range, valid, (drive <= DRIVE_MAX) && (drive >= -DRIVE_MAX), "drive out of range")

	// A saturated result sits exactly on a limit.
	`SPBB_ASSERT_NOW(a_sat_on_limit, valid && drive_saturated, (drive == DRIVE_MAX) || (drive == -DRIVE_MAX), "saturated drive off a limit")

	// A stalled result item is held unchanged.
	`SPBB_ASSERT_NEXT(a_result_held, valid && !ready, valid && $stable(drive) && $stable(drive_saturated), "stalled result item changed")

endmodule

bind speed_pid_with_bang_bang_fallback_core spbb_checker u_spbb_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.valid           (results.valid),
	.ready           (results.ready),
	.drive           (results.drive),
	.drive_saturated (results.drive_saturated)
);
`default_nettype wire

@@ dv/drive_check_pkg.sv @@
// Scoreboard for the speed PID core: drive prediction and result checking.
`timescale 1ns / 1ps
package drive_check_pkg;
	import spbb_pkg::*;

	// Predicts the drive of each control step and checks results in order.
	class drive_scoreboard;
		cfg_t    gains;
		state_t  st;
		result_t expected_drives[$];
		int      mismatches;

		function new();
			gains.kp                   = '0;
			gains.ki                   = '0;
			gains.kd                   = '0;
			gains.forward_fault_drive  = FAULT_DRIVE_RESET;
			gains.backward_fault_drive = FAULT_DRIVE_RESET;
			st.integrator              = '0;
			st.previous_error          = '0;
			st.previous_error_valid    = 1'b1;
			mismatches                 = 0;
		endfunction

		static function longint limit(longint v, longint lim);
			if (v > lim)
				return lim;
			if (v < -lim)
				return -lim;
			return v;
		endfunction

		// Mirrors a register write; unknown indexes leave everything unchanged.
		function void write_reg(logic [2:0] index, logic [15:0] data);
			case (index)
				REG_PROPORTIONAL_GAIN:    gains.kp = data;
				REG_INTEGRAL_GAIN:        gains.ki = data;
				REG_DERIVATIVE_GAIN:      gains.kd = data;
				REG_FORWARD_FAULT_DRIVE:  gains.forward_fault_drive = data[13:0];
				REG_BACKWARD_FAULT_DRIVE: gains.backward_fault_drive = data[13:0];
				default: ;
			endcase
		endfunction

		// Works out the result of one accepted input item, if it has one.
		function void note_item(item_t it);
			longint  tgt;
			longint  err;
			longint  integ;
			longint  dterm;
			longint  sum;
			result_t r;
			if (it.mode) begin
				st.integrator = '0;
				return;
			end
			tgt = limit(longint'(it.target_speed), longint'(TARGET_LIMIT));
			if (it.feedback_fault) begin
				// Bang-bang drive by direction; the integrator is held.
				if (tgt > longint'(FAULT_DEADBAND))
					sum = -longint'(gains.forward_fault_drive);
				else if (tgt < -longint'(FAULT_DEADBAND))
					sum = longint'(gains.backward_fault_drive);
				else
					sum = 0;
				st.previous_error       = '0;
				st.previous_error_valid = 1'b0;
			end else begin
				err   = tgt - longint'(it.measured_speed);
				integ = limit(longint'(st.integrator) + ((err * longint'(gains.ki)) >>> 8),
					longint'(INTEGRATOR_LIMIT));
				st.integrator = integ[13:0];
				dterm = 0;
				if (st.previous_error_valid)
					dterm = limit(-(((err - longint'(st.previous_error))
						* longint'(gains.kd)) >>> 8), longint'(DTERM_LIMIT));
				sum = -((err * longint'(gains.kp)) >>> 8) - integ + dterm;
				st.previous_error       = err[16:0];
				st.previous_error_valid = 1'b1;
			end
			r.drive_saturated = (sum > longint'(DRIVE_LIMIT)) || (sum < -longint'(DRIVE_LIMIT));
			sum = limit(sum, longint'(DRIVE_LIMIT));
			r.drive = sum[14:0];
			expected_drives.push_back(r);
		endfunction

		// Compares one accepted result with the oldest expected drive.
		function void check_result(result_t got);
			result_t want;
			if (expected_drives.size() == 0) begin
				$error("unexpected result: drive %0d saturated %0d",
					got.drive, got.drive_saturated);
				mismatches++;
				return;
			end
			want = expected_drives.pop_front();
			if (got.drive !== want.drive) begin
				$error("drive: expected %0d, actual %0d", want.drive, got.drive);
				mismatches++;
			end
			if (got.drive_saturated !== want.drive_saturated) begin
				$error("drive_saturated: expected %0d, actual %0d",
					want.drive_saturated, got.drive_saturated);
				mismatches++;
			end
		endfunction

		function int pending();
			return expected_drives.size();
		endfunction
	endclass

endpackage

@@ dv/tb_top.sv @@
// Top level of the speed PID core testbench: clock, reset, stimulus and result monitor.
`timescale 1ns / 1ps
module tb_top;
	import spbb_pkg::*;
	import drive_check_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 4;
	localparam int PHASE_ITEMS    = 420;
	localparam logic [2:0] REG_UNUSED_LO = 3'd5;

	logic clk = 1'b0;
	logic arst_n;

	spbb_in_if  items_ch();
	spbb_out_if results_ch();
	spbb_cfg_if cfg_ch();

	speed_pid_with_bang_bang_fallback_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_ch),
		.results (results_ch),
		.cfg     (cfg_ch)
	);

	drive_scoreboard sb = new();

	int gap_pct;
	int stall_pct;
	int quiet_cycles;

	always #2 clk = ~clk;

	// The receiver stalls at random, driven on the falling edge.
	always @(negedge clk) begin
		results_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	// Result monitor and watchdog, sampled on the rising edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (results_ch.valid && results_ch.ready)
				sb.check_result('{drive: results_ch.drive,
					drive_saturated: results_ch.drive_saturated});
			if ((items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// Offers one input item after an optional random gap, then waits for acceptance.
	task automatic send_item(item_t it);
		while ($urandom_range(0, 99) < gap_pct) begin
			items_ch.valid <= 1'b0;
			@(negedge clk);
		end
		items_ch.valid          <= 1'b1;
		items_ch.mode           <= it.mode;
		items_ch.target_speed   <= it.target_speed;
		items_ch.measured_speed <= it.measured_speed;
		items_ch.feedback_fault <= it.feedback_fault;
		@(posedge clk);
		while (!items_ch.ready)
			@(posedge clk);
		sb.note_item(it);
		@(negedge clk);
	endtask

	task automatic send_fields(logic m, int tgt, int meas, logic fault);
		item_t it;
		it.mode           = m;
		it.target_speed   = tgt[15:0];
		it.measured_speed = meas[14:0];
		it.feedback_fault = fault;
		send_item(it);
	endtask

	// Holds the sender off until every expected result has arrived, then lets the core idle.
	task automatic drain_results();
		items_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// One register write; the caller lowers valid after the last write of a batch.
	task automatic write_reg(logic [2:0] index, logic [15:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		sb.write_reg(index, data);
		@(negedge clk);
	endtask

	task automatic configure(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
			logic [15:0] fwd, logic [15:0] bwd, bit with_unused);
		write_reg(REG_PROPORTIONAL_GAIN, kp);
		write_reg(REG_INTEGRAL_GAIN, ki);
		write_reg(REG_DERIVATIVE_GAIN, kd);
		write_reg(REG_FORWARD_FAULT_DRIVE, fwd);
		write_reg(REG_BACKWARD_FAULT_DRIVE, bwd);
		if (with_unused)
			write_reg(REG_UNUSED_LO + 3'($urandom_range(0, 2)), 16'($urandom));
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [15:0] rand_gain();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 1024));
		endcase
	endfunction

	function automatic logic [15:0] rand_fault_drive();
		case ($urandom_range(0, 7))
			0: return 16'd0;
			1: return 16'h3FFF;
			2: return 16'd15000;
			3: return 16'($urandom);
			default: return 16'($urandom_range(0, 15000));
		endcase
	endfunction

	task automatic random_config();
		configure(rand_gain(), rand_gain(), rand_gain(), rand_fault_drive(),
			rand_fault_drive(), $urandom_range(0, 3) == 0);
	endtask

	// Mostly plausible speeds near the target, with full-range noise mixed in.
	task automatic send_random_item();
		int tgt;
		int meas;
		case ($urandom_range(0, 9))
			0: tgt = int'($urandom_range(0, 65535)) - 32768;
			1: tgt = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(99, 102));
			2: tgt = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1499, 1501));
			default: tgt = int'($urandom_range(0, 4000)) - 2000;
		endcase
		case ($urandom_range(0, 9))
			0: meas = int'($urandom_range(0, 32767)) - 16384;
			1: meas = $urandom_range(0, 1) ? 16383 : -16384;
			default: meas = (tgt > 1500 ? 1500 : (tgt < -1500 ? -1500 : tgt))
				+ int'($urandom_range(0, 600)) - 300;
		endcase
		send_fields($urandom_range(0, 19) == 0, tgt, meas, $urandom_range(0, 6) == 0);
	endtask

	initial begin
		arst_n                  = 1'b0;
		items_ch.valid          = 1'b0;
		items_ch.mode           = 1'b0;
		items_ch.target_speed   = '0;
		items_ch.measured_speed = '0;
		items_ch.feedback_fault = 1'b0;
		results_ch.ready        = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.index            = REG_PROPORTIONAL_GAIN;
		cfg_ch.data             = '0;
		gap_pct                 = 6;
		stall_pct               = 70;
		quiet_cycles            = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: zero gains, so only the fault drive can move the output.
		send_fields(0, 500, 0, 0);
		send_fields(0, 200, 0, 1);
		send_fields(0, -200, 0, 1);
		send_fields(0, 100, 0, 1);
		send_fields(0, -101, 0, 1);

		// Moderate gains: target clamp, skipped D after a fault, clear items.
		drain_results();
		configure(16'd256, 16'd64, 16'd512, 16'd3000, 16'd1200, 1'b0);
		send_fields(0, 32767, 0, 0);
		send_fields(0, -32768, 16383, 0);
		send_fields(0, 0, -16384, 0);
		send_fields(1, 1234, 555, 1);
		send_fields(0, 101, 0, 1);
		send_fields(0, 1500, 1400, 0);
		send_fields(0, 1500, 1400, 0);
		send_fields(0, -1500, 0, 0);
		send_fields(1, 0, 0, 0);

		// Full gains and an oversized fault drive: every clamp and the saturation flag.
		drain_results();
		configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd15000, 1'b1);
		send_fields(0, 1500, -16384, 0);
		send_fields(0, -1500, 16383, 0);
		send_fields(0, 200, 0, 1);
		send_fields(0, -200, 0, 1);
		send_fields(0, 0, 0, 0);
		send_fields(0, 1, 0, 0);
		send_fields(0, -1, 0, 0);

		// All registers at their lowest.
		drain_results();
		configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
		send_fields(0, -32768, -16384, 1);
		send_fields(0, 32767, 16383, 0);

		// Random items in three phases of differing gaps and stalls, with fresh settings now and then.
		for (int phase = 0; phase < 3; phase++) begin
			gap_pct   = (phase == 0) ? 6 : ((phase == 1) ? 70 : 0);
			stall_pct = (phase == 0) ? 70 : ((phase == 1) ? 6 : 0);
			drain_results();
			random_config();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if ((n % 105) == 104) begin
					drain_results();
					random_config();
				end else if ($urandom_range(0, 99) == 0) begin
					drain_results();
				end
				send_random_item();
			end
		end

		drain_results();
		repeat (10) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.mismatches++;
		end
		if (sb.mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
